// File: sv/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with search.
// ---------------------------------------------------------------------------
package bdq_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_COUNT      = 3'd4,
    OP_DELETE     = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_DEDUP      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SHIFT,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch request, reset walk
    logic walk;    // compare/advance one step
    logic shift;   // move one entry toward front
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic shift_done;
    logic need_walk;
  } sts_t;
endpackage
`default_nettype wire

// File: sv/bdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdq_ram
// Generic single-write, dual-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// File: sv/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdq_ctrl
// Controller: sequences accept, walk, shift and result phases.
// ---------------------------------------------------------------------------
module bdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bdq_pkg::cmd_t      cmd,
  input  wire bdq_pkg::sts_t sts
);
  import bdq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_WALK;
      S_WALK: begin
        if (sts.walk_done) state_nxt = sts.need_walk ? S_SHIFT : S_RESULT;
      end
      S_SHIFT:  if (sts.shift_done) state_nxt = S_RESULT;
      S_RESULT: if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready  = rst_n;
        cmd.start = in_valid && rst_n;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
      end
      S_RESULT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: sv/bdq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdq_dp
// Datapath: entry RAM, fill count, walk pointers and result registers.
// Storage is a ring: head points at the front entry.
// ---------------------------------------------------------------------------
module bdq_dp #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [2:0]                 in_opcode,
  input  wire logic signed [31:0]         in_value_in,
  input  wire bdq_pkg::cmd_t              cmd,
  output bdq_pkg::sts_t                   sts,
  output logic [1:0]                      out_status,
  output logic signed [31:0]              out_value_out,
  output logic [4:0]                      out_match_count,
  output logic [4:0]                      out_size_now,
  output logic                            out_empty
);
  import bdq_pkg::*;

  // Walk steps: i = logical read index, j = inner index (dedup) or write idx
  op_t                op_r;
  logic [WORD_W-1:0]  val_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      i_r, i_nxt;       // outer logical index
  logic [CW-1:0]      j_r, j_nxt;       // inner / kept index
  logic [CW-1:0]      kept_r, kept_nxt;
  logic [CW-1:0]      mc_r, mc_nxt;
  logic               phase_r, phase_nxt; // 0: issue read, 1: data back
  logic               found_r, found_nxt;
  logic               done_r, done_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [WORD_W-1:0]  vo_r, vo_nxt;

  logic               we;
  logic [AW-1:0]      waddr, ra, rb;
  logic [WORD_W-1:0]  wdata, rda, rdb;

  bdq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb)
  );

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                         input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] head_dec;
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      head_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      head_r <= head_nxt;
    end
    op_r    <= cmd.start ? op_t'(in_opcode) : op_r;
    val_r   <= cmd.start ? in_value_in : val_r;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    kept_r  <= kept_nxt;
    mc_r    <= mc_nxt;
    phase_r <= phase_nxt;
    found_r <= found_nxt;
    done_r  <= done_nxt;
    st_r    <= st_nxt;
    vo_r    <= vo_nxt;
  end

  logic full, empty;
  assign full  = (fill_r == CW'(DEPTH));
  assign empty = (fill_r == '0);

  always_comb begin
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    kept_nxt  = kept_r;
    mc_nxt    = mc_r;
    phase_nxt = phase_r;
    found_nxt = found_r;
    done_nxt  = done_r;
    st_nxt    = st_r;
    vo_nxt    = vo_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = val_r;
    ra        = phys(head_r, i_r);
    rb        = phys(head_r, j_r);
    sts       = '0;

    if (cmd.start) begin
      i_nxt     = '0;
      j_nxt     = '0;
      kept_nxt  = '0;
      mc_nxt    = '0;
      phase_nxt = 1'b0;
      found_nxt = 1'b0;
      done_nxt  = 1'b0;
      st_nxt    = ST_DONE;
      vo_nxt    = '0;
    end

    if (cmd.walk) begin
      case (op_r)
        OP_PUSH_FRONT: begin
          sts.walk_done = 1'b1;
          if (full) st_nxt = ST_FULL;
          else begin
            we       = 1'b1;
            waddr    = head_dec;
            head_nxt = head_dec;
            fill_nxt = fill_r + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          sts.walk_done = 1'b1;
          if (full) st_nxt = ST_FULL;
          else begin
            we       = 1'b1;
            waddr    = phys(head_r, fill_r);
            fill_nxt = fill_r + CW'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            sts.walk_done = 1'b1;
            st_nxt = ST_NOTFOUND;
          end else if (!phase_r) begin
            i_nxt     = (op_r == OP_POP_FRONT) ? '0 : fill_r - CW'(1);
            phase_nxt = 1'b1;
          end else if (!done_r) begin
            done_nxt = 1'b1; // read issued with i_r this cycle
          end else begin
            sts.walk_done = 1'b1;
            vo_nxt   = rda;
            fill_nxt = fill_r - CW'(1);
            if (op_r == OP_POP_FRONT) head_nxt = phys(head_r, CW'(1));
          end
        end
        OP_COUNT, OP_DELETE: begin
          // phase 0: address i, phase 1: compare data for i
          if (i_r == fill_r && !phase_r) begin
            sts.walk_done = 1'b1;
            if (op_r == OP_DELETE) st_nxt = ST_NOTFOUND;
          end else if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            phase_nxt = 1'b0;
            if (rda == val_r) begin
              if (op_r == OP_COUNT) mc_nxt = mc_r + CW'(1);
              else begin
                sts.walk_done  = 1'b1;
                sts.need_walk  = 1'b1;
                found_nxt      = 1'b1;
                j_nxt          = i_r;
              end
            end
            if (!(op_r == OP_DELETE && rda == val_r)) i_nxt = i_r + CW'(1);
          end
        end
        OP_CLEAR: begin
          sts.walk_done = 1'b1;
          fill_nxt = '0;
        end
        default: begin // dedup: i outer, j inner over kept
          if (i_r == fill_r && !phase_r) begin
            sts.walk_done = 1'b1;
            fill_nxt = kept_r;
          end else if (!phase_r) begin
            phase_nxt = 1'b1;
            j_nxt     = '0;
            found_nxt = 1'b0;
          end else if (j_r == kept_r || found_r) begin
            // hold the write-back until done_r is set, so rda is current
            if (!done_r) done_nxt = 1'b1;
            else begin
              done_nxt  = 1'b0;
              phase_nxt = 1'b0;
              if (!found_r) begin
                we       = 1'b1;
                waddr    = phys(head_r, kept_r);
                wdata    = rda;
                kept_nxt = kept_r + CW'(1);
              end
              i_nxt = i_r + CW'(1);
            end
          end else if (!done_r) begin
            done_nxt = 1'b1; // read of j in flight
          end else begin
            done_nxt = 1'b0;
            if (rdb == rda) found_nxt = 1'b1;
            else j_nxt = j_r + CW'(1);
          end
        end
      endcase
    end

    if (cmd.shift) begin
      // close gap at j: entry[j] <= entry[j+1]
      rb = phys(head_r, j_r + CW'(1));
      if (j_r + CW'(1) >= fill_r) begin
        sts.shift_done = 1'b1;
        fill_nxt = fill_r - CW'(1);
      end else if (!done_r) begin
        done_nxt = 1'b1;
      end else begin
        done_nxt = 1'b0;
        we       = 1'b1;
        waddr    = phys(head_r, j_r);
        wdata    = rdb;
        j_nxt    = j_r + CW'(1);
      end
    end
  end

  assign out_status      = st_r;
  assign out_value_out   = vo_r;
  assign out_match_count = 5'(mc_r) & {5{op_r == OP_COUNT}};
  assign out_size_now    = 5'(fill_r);
  assign out_empty       = (fill_r == '0);
endmodule
`default_nettype wire

// File: sv/bounded_deque_with_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed words with count, delete and dedup.
//
//   channel | ports                                       | direction
//   in      | in_valid/in_ready, in_opcode, in_value_in   | request in
//   out     | out_valid/out_ready, out_status..out_empty  | result out
//
// Push/clear need no RAM read; pop reads the front or back entry. Count and
// delete walk the store entry by entry; a delete that finds its value then
// shifts later entries forward. Dedup keeps each first value. One request
// at a time; the result holds until taken. A synchronous reset empties the store.
// ---------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_opcode,
  input  wire logic signed [31:0] in_value_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_value_out,
  output logic [4:0]              out_match_count,
  output logic [4:0]              out_size_now,
  output logic                    out_empty
);
  import bdq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bdq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  bdq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_opcode(in_opcode), .in_value_in(in_value_in),
    .cmd(cmd), .sts(sts), .out_status(out_status), .out_value_out(out_value_out),
    .out_match_count(out_match_count), .out_size_now(out_size_now),
    .out_empty(out_empty)
  );
endmodule
`default_nettype wire

// File: sv/bdq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the bounded deque.
// ---------------------------------------------------------------------------
module bdq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [4:0] out_size_now,
  input wire logic       out_empty
);
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty == (out_size_now == 5'd0))) else $error("empty");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("overlap");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3)) else $error("status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_size_now)) else $error("hold");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("busy");
endmodule

bind bounded_deque_with_search bdq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_size_now(out_size_now), .out_empty(out_empty)
);
`default_nettype wire
